// ===== rtl/ellipse_fill_and_ring_rasterizer_core_macros.svh =====
// Assertion macros used by the rasterizer controller.
`ifndef ELLIPSE_FILL_AND_RING_RASTERIZER_CORE_MACROS_SVH
`define ELLIPSE_FILL_AND_RING_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication on clk, off during reset
`define EFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, off during reset
`define EFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/efr_pkg.sv =====
// Package: widths, codes and controller/datapath interface types for the rasterizer.
package efr_pkg;

    localparam int COORD_WIDTH  = 12;
    localparam int RADIUS_WIDTH = 10;
    localparam int OUT_WIDTH    = COORD_WIDTH + 1;
    localparam int SQ_WIDTH     = 2 * RADIUS_WIDTH;
    localparam int PROD_WIDTH   = 4 * RADIUS_WIDTH;
    localparam int BIT_WIDTH    = $clog2(RADIUS_WIDTH);

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;
    localparam logic KIND_SPAN  = 1'b0;
    localparam logic KIND_QUAD  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FILL_SQ,
        OP_FILL_TGT,
        OP_ROOT_SQ,
        OP_ROOT_CMP,
        OP_FILL_EMIT,
        OP_RING_MUL,
        OP_RING_UPD,
        OP_BEGIN_SQ,
        OP_BEGIN_ERR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   done;
    } dp_cmd_t;

    typedef struct packed {
        logic ry_zero;
        logic row_last;
        logic rings_nz;
        logic ring_exit;
        logic ring_more;
        logic bit_last;
    } dp_stat_t;

endpackage

// ===== rtl/efr_req_if.sv =====
// Request channel: start/tick words with ellipse parameters.
interface efr_req_if
    import efr_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic signed [COORD_WIDTH-1:0]  center_x;
    logic signed [COORD_WIDTH-1:0]  center_y;
    logic [RADIUS_WIDTH-1:0]        radius_x;
    logic [RADIUS_WIDTH-1:0]        radius_y;
    logic [RADIUS_WIDTH-1:0]        border_width;

    modport source (output valid, func, center_x, center_y, radius_x, radius_y,
                    border_width, input ready);
    modport sink (input valid, func, center_x, center_y, radius_x, radius_y,
                  border_width, output ready);
endinterface

// ===== rtl/efr_rsp_if.sv =====
// Response channel: one primitive word (span or quad).
interface efr_rsp_if
    import efr_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [OUT_WIDTH-1:0]   x_low;
    logic signed [OUT_WIDTH-1:0]   x_high;
    logic signed [OUT_WIDTH-1:0]   y_low;
    logic signed [OUT_WIDTH-1:0]   y_high;
    logic                          done_res;

    modport source (output valid, kind, x_low, x_high, y_low, y_high, done_res,
                    input ready);
    modport sink (input valid, kind, x_low, x_high, y_low, y_high, done_res,
                  output ready);
endinterface

// ===== rtl/efr_dp.sv =====
// Datapath: saved ellipse, integer root, Bresenham walk and output word registers.
module efr_dp
    import efr_pkg::*;
(
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic [RADIUS_WIDTH-1:0]       radius_x,
    input  logic [RADIUS_WIDTH-1:0]       radius_y,
    input  logic [RADIUS_WIDTH-1:0]       border_width,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    output logic                          kind,
    output logic signed [OUT_WIDTH-1:0]   x_low,
    output logic signed [OUT_WIDTH-1:0]   x_high,
    output logic signed [OUT_WIDTH-1:0]   y_low,
    output logic signed [OUT_WIDTH-1:0]   y_high,
    output logic                          done_res
);

    localparam int RW = RADIUS_WIDTH;

    logic signed [COORD_WIDTH-1:0] cx_reg, cy_reg;
    logic [RW-1:0]                 rx_reg, ry_reg;
    logic [RW:0]                   rings_reg;
    logic signed [RW+1:0]          row_reg;
    logic [RW:0]                   ring_x_reg;
    logic signed [RW+1:0]          ring_y_reg;
    logic signed [PROD_WIDTH-1:0]  err_reg;
    logic [SQ_WIDTH-1:0]           rx2_reg, ry2_reg, y2_reg, csq_reg;
    logic [PROD_WIDTH-1:0]         target_reg;
    logic [RW-1:0]                 d_reg;
    logic [BIT_WIDTH-1:0]          bit_reg;
    logic signed [PROD_WIDTH:0]    a_reg, b_reg;

    logic                          kind_reg, done_reg;
    logic signed [OUT_WIDTH-1:0]   xl_reg, xh_reg, yl_reg, yh_reg;

    logic [RW-1:0]                 cand;
    logic [PROD_WIDTH-1:0]         root_prod;
    logic signed [2*RW+3:0]        ysq;
    logic signed [RW+2:0]          tby;
    logic signed [3*RW+3:0]        begin_prod;
    logic [RW+1:0]                 tax;
    logic [3*RW+1:0]               a_prod;
    logic signed [RW+3:0]          tbr;
    logic signed [3*RW+4:0]        b_prod;
    logic signed [PROD_WIDTH:0]    e2, a_step, b_step;
    logic                          cond_x, cond_y, dec_y;
    logic signed [PROD_WIDTH:0]    err_sum;

    assign cand      = d_reg | (RW'(1) << bit_reg);
    assign root_prod = PROD_WIDTH'(csq_reg * ry2_reg);
    assign ysq       = row_reg * row_reg;
    assign tby       = $signed({2'b00, ry_reg, 1'b0}) - (RW+3)'(1);
    assign begin_prod = tby * $signed({1'b0, rx2_reg});
    assign tax       = {ring_x_reg, 1'b1};
    assign a_prod    = tax * ry2_reg;
    assign tbr       = $signed({ring_y_reg, 1'b0}) - (RW+4)'(1);
    assign b_prod    = tbr * $signed({1'b0, rx2_reg});

    assign e2     = {err_reg, 1'b0};
    assign cond_x = e2 < a_reg;
    assign cond_y = e2 > -b_reg;
    assign dec_y  = cond_y || !cond_x;
    assign a_step = a_reg + (PROD_WIDTH+1)'({ry2_reg, 1'b0});
    assign b_step = b_reg - (PROD_WIDTH+1)'({rx2_reg, 1'b0});
    assign err_sum = (PROD_WIDTH+1)'(err_reg)
                   + (cond_x ? a_step : '0) - (cond_y ? b_step : '0);

    assign stat.ry_zero   = ry_reg == '0;
    assign stat.row_last  = row_reg == $signed({2'b00, ry_reg});
    assign stat.rings_nz  = rings_reg != '0;
    assign stat.ring_exit = (ring_y_reg == '0) && dec_y;
    assign stat.ring_more = (rings_reg > (RW+1)'(1)) && (rx_reg != '0) && (ry_reg != '0);
    assign stat.bit_last  = bit_reg == '0;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                cx_reg    <= center_x;
                cy_reg    <= center_y;
                rx_reg    <= radius_x;
                ry_reg    <= radius_y;
                rings_reg <= {1'b0, border_width};
                row_reg   <= -$signed({2'b00, radius_y});
            end
            OP_FILL_SQ:
            begin
                rx2_reg <= rx_reg * rx_reg;
                ry2_reg <= ry_reg * ry_reg;
                y2_reg  <= ysq[SQ_WIDTH-1:0];
            end
            OP_FILL_TGT:
            begin
                target_reg <= rx2_reg * (ry2_reg - y2_reg);
                d_reg      <= stat.ry_zero ? rx_reg : '0;
                bit_reg    <= BIT_WIDTH'(RW - 1);
            end
            OP_ROOT_SQ:
            begin
                csq_reg <= cand * cand;
            end
            OP_ROOT_CMP:
            begin
                if (root_prod <= target_reg)
                begin
                    d_reg <= cand;
                end
                bit_reg <= bit_reg - BIT_WIDTH'(1);
            end
            OP_FILL_EMIT:
            begin
                kind_reg <= KIND_SPAN;
                xl_reg   <= OUT_WIDTH'(cx_reg) - OUT_WIDTH'(d_reg);
                xh_reg   <= OUT_WIDTH'(cx_reg) + OUT_WIDTH'(d_reg);
                yl_reg   <= OUT_WIDTH'(cy_reg) + OUT_WIDTH'(row_reg);
                yh_reg   <= OUT_WIDTH'(cy_reg) + OUT_WIDTH'(row_reg);
                done_reg <= cmd.done;
                row_reg  <= row_reg + (RW+2)'(1);
            end
            OP_RING_MUL:
            begin
                a_reg <= (PROD_WIDTH+1)'(a_prod);
                b_reg <= (PROD_WIDTH+1)'(b_prod);
            end
            OP_RING_UPD:
            begin
                kind_reg   <= KIND_QUAD;
                xl_reg     <= OUT_WIDTH'(cx_reg) - OUT_WIDTH'(ring_x_reg);
                xh_reg     <= OUT_WIDTH'(cx_reg) + OUT_WIDTH'(ring_x_reg);
                yl_reg     <= OUT_WIDTH'(cy_reg) - OUT_WIDTH'(ring_y_reg);
                yh_reg     <= OUT_WIDTH'(cy_reg) + OUT_WIDTH'(ring_y_reg);
                done_reg   <= cmd.done;
                ring_x_reg <= ring_x_reg + (RW+1)'(cond_x);
                ring_y_reg <= ring_y_reg - (RW+2)'(dec_y);
                err_reg    <= PROD_WIDTH'(err_sum);
                if (stat.ring_exit)
                begin
                    rings_reg <= rings_reg - (RW+1)'(1);
                    if (stat.ring_more)
                    begin
                        rx_reg <= rx_reg - RW'(1);
                        ry_reg <= ry_reg - RW'(1);
                    end
                end
            end
            OP_BEGIN_SQ:
            begin
                rx2_reg    <= rx_reg * rx_reg;
                ry2_reg    <= ry_reg * ry_reg;
                ring_x_reg <= '0;
                ring_y_reg <= $signed({2'b00, ry_reg});
            end
            OP_BEGIN_ERR:
            begin
                err_reg <= $signed(PROD_WIDTH'({1'b0, ry2_reg})) - PROD_WIDTH'(begin_prod);
            end
            default:
            begin
            end
        endcase
    end

    assign kind     = kind_reg;
    assign x_low    = xl_reg;
    assign x_high   = xh_reg;
    assign y_low    = yl_reg;
    assign y_high   = yh_reg;
    assign done_res = done_reg;

endmodule

// ===== rtl/efr_ctrl.sv =====
// Controller: phase tracking, sequencing of datapath steps and output word valid.
module efr_ctrl
    import efr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_func,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);
    `include "ellipse_fill_and_ring_rasterizer_core_macros.svh"

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FILL_SQ   = 4'd1;
    localparam logic [3:0] S_FILL_TGT  = 4'd2;
    localparam logic [3:0] S_ROOT_SQ   = 4'd3;
    localparam logic [3:0] S_ROOT_CMP  = 4'd4;
    localparam logic [3:0] S_FILL_EMIT = 4'd5;
    localparam logic [3:0] S_RING_MUL  = 4'd6;
    localparam logic [3:0] S_RING_UPD  = 4'd7;
    localparam logic [3:0] S_BEGIN_SQ  = 4'd8;
    localparam logic [3:0] S_BEGIN_ERR = 4'd9;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_FILL = 2'd1;
    localparam logic [1:0] PH_RING = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_emit;

    assign can_emit  = !out_valid_reg || rsp_ready;
    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd.op         = OP_NONE;
        cmd.done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_func == FUNC_START)
                    begin
                        cmd.op     = OP_LOAD;
                        phase_next = PH_FILL;
                    end
                    else if (phase_reg == PH_FILL)
                    begin
                        state_next = S_FILL_SQ;
                    end
                    else if (phase_reg == PH_RING)
                    begin
                        state_next = S_RING_MUL;
                    end
                end
            end
            S_FILL_SQ:
            begin
                cmd.op     = OP_FILL_SQ;
                state_next = S_FILL_TGT;
            end
            S_FILL_TGT:
            begin
                cmd.op     = OP_FILL_TGT;
                state_next = stat.ry_zero ? S_FILL_EMIT : S_ROOT_SQ;
            end
            S_ROOT_SQ:
            begin
                cmd.op     = OP_ROOT_SQ;
                state_next = S_ROOT_CMP;
            end
            S_ROOT_CMP:
            begin
                cmd.op     = OP_ROOT_CMP;
                state_next = stat.bit_last ? S_FILL_EMIT : S_ROOT_SQ;
            end
            S_FILL_EMIT:
            begin
                if (can_emit)
                begin
                    cmd.op         = OP_FILL_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (stat.row_last)
                    begin
                        if (stat.rings_nz)
                        begin
                            phase_next = PH_RING;
                            state_next = S_BEGIN_SQ;
                        end
                        else
                        begin
                            cmd.done   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            S_RING_MUL:
            begin
                cmd.op     = OP_RING_MUL;
                state_next = S_RING_UPD;
            end
            S_RING_UPD:
            begin
                if (can_emit)
                begin
                    cmd.op         = OP_RING_UPD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (stat.ring_exit)
                    begin
                        if (stat.ring_more)
                        begin
                            state_next = S_BEGIN_SQ;
                        end
                        else
                        begin
                            cmd.done   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            S_BEGIN_SQ:
            begin
                cmd.op     = OP_BEGIN_SQ;
                state_next = S_BEGIN_ERR;
            end
            S_BEGIN_ERR:
            begin
                cmd.op     = OP_BEGIN_ERR;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `EFR_ASSERT_NEXT(a_start_enters_fill, req_valid && req_ready && req_func == FUNC_START, phase_reg == PH_FILL && state_reg == S_IDLE, "start word did not arm the fill phase")
    `EFR_ASSERT_NEXT(a_idle_tick_quiet, req_valid && req_ready && req_func == FUNC_TICK && phase_reg == PH_IDLE, state_reg == S_IDLE && !($rose(out_valid_reg)), "tick in idle phase produced work")
    `EFR_ASSERT_NEXT(a_root_ends_in_emit, state_reg == S_ROOT_CMP && stat.bit_last, state_reg == S_FILL_EMIT, "root search did not finish into span emit")
    `EFR_ASSERT_NEXT(a_done_goes_idle, cmd.done, phase_reg == PH_IDLE && out_valid_reg, "last primitive did not close the ellipse")

endmodule

// ===== rtl/ellipse_fill_and_ring_rasterizer_core.sv =====
// Top level of the ellipse fill and ring rasterizer.
// A start word (func 0) loads center, radii and border width and yields no output; each tick
// word (func 1) then yields one primitive: first the fill spans for rows -ry..ry, then the
// outline quads of each border ring, the last one flagged by done_res; ticks with nothing
// pending yield nothing. One word is in work at a time. A fill span's half width comes from
// a bit-serial integer square root (skipped when the y radius is zero), which handles each
// result bit with a squaring multiplier step and then a product/compare step. An outline
// quad is made by a multiply step (both multiplies) and then the error update, and the next
// ring is set up (squares, then the initial error) after the last span or the last quad of
// a ring. A finished word waits in an output register, and a new request word is taken
// while it waits.
module ellipse_fill_and_ring_rasterizer_core
    import efr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    efr_req_if.sink   req,
    efr_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    efr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    efr_dp u_dp (
        .clk          (clk),
        .center_x     (req.center_x),
        .center_y     (req.center_y),
        .radius_x     (req.radius_x),
        .radius_y     (req.radius_y),
        .border_width (req.border_width),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (rsp.kind),
        .x_low        (rsp.x_low),
        .x_high       (rsp.x_high),
        .y_low        (rsp.y_low),
        .y_high       (rsp.y_high),
        .done_res     (rsp.done_res)
    );

endmodule

// ===== tb/sv/ellipse_fill_and_ring_rasterizer_core_tb.sv =====
// Testbench for the ellipse fill and ring rasterizer: directed table, then random ellipses.
module ellipse_fill_and_ring_rasterizer_core_tb;
    import efr_pkg::*;

    localparam int N_ITEMS    = 1350;
    localparam int QUIET_FROM = 1200;
    localparam int IDLE_LIMIT = 4000;

    typedef enum int {RS_IDLE, RS_FILL, RS_RING} raster_phase_t;

    typedef struct packed {
        logic                        kind;
        logic signed [OUT_WIDTH-1:0] x_low;
        logic signed [OUT_WIDTH-1:0] x_high;
        logic signed [OUT_WIDTH-1:0] y_low;
        logic signed [OUT_WIDTH-1:0] y_high;
        logic                        done_res;
    } prim_t;

    typedef struct {
        logic                           func;
        logic signed [COORD_WIDTH-1:0]  cx;
        logic signed [COORD_WIDTH-1:0]  cy;
        logic [RADIUS_WIDTH-1:0]        rx;
        logic [RADIUS_WIDTH-1:0]        ry;
        logic [RADIUS_WIDTH-1:0]        bw;
        int                             reps;
        bit                             typed;
        prim_t                          exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    efr_req_if req ();
    efr_rsp_if rsp ();

    ellipse_fill_and_ring_rasterizer_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    raster_phase_t ph = RS_IDLE;
    longint s_cx = 0, s_cy = 0, s_rx = 0, s_ry = 0, s_rings = 0, s_row = 0;
    longint r_x = 0, r_y = 0, r_err = 0, r_rx2 = 0, r_ry2 = 0;

    prim_t prim_q[$];
    row_t  dir_tab[$];
    int    n_items = 0;
    int    errors = 0;
    int    idle_cyc = 0;
    bit    quiet = 0;
    int    rsp_stall = 0;

    function automatic longint span_half(longint rx, longint ry, longint y);
        longint ry2, tgt, d, c;
        if (ry == 0)
            return rx;
        ry2 = ry * ry;
        tgt = rx * rx * (ry * ry - y * y);
        d = 0;
        for (int b = RADIUS_WIDTH - 1; b >= 0; b--)
        begin
            c = d | (longint'(1) << b);
            if (c * c * ry2 <= tgt)
                d = c;
        end
        return d;
    endfunction

    function automatic void ring_setup();
        r_rx2 = s_rx * s_rx;
        r_ry2 = s_ry * s_ry;
        r_x = 0;
        r_y = s_ry;
        r_err = r_ry2 - (2 * s_ry - 1) * r_rx2;
    endfunction

    task automatic raster_step(input logic f, input logic signed [COORD_WIDTH-1:0] cx,
                               input logic signed [COORD_WIDTH-1:0] cy,
                               input logic [RADIUS_WIDTH-1:0] rx,
                               input logic [RADIUS_WIDTH-1:0] ry,
                               input logic [RADIUS_WIDTH-1:0] bw,
                               output bit got, output prim_t p);
        longint y, x, dx, e2;
        bit moved, dn;
        got = 0;
        p = '0;
        dn = 0;
        moved = 0;
        if (f == FUNC_START)
        begin
            s_cx = longint'(cx);
            s_cy = longint'(cy);
            s_rx = longint'(rx);
            s_ry = longint'(ry);
            s_rings = longint'(bw);
            s_row = -s_ry;
            ph = RS_FILL;
        end
        else if (ph == RS_FILL)
        begin
            y = s_row;
            dx = span_half(s_rx, s_ry, y);
            s_row++;
            if (s_row > s_ry)
            begin
                if (s_rings > 0)
                begin
                    ph = RS_RING;
                    ring_setup();
                end
                else
                begin
                    ph = RS_IDLE;
                    dn = 1;
                end
            end
            got = 1;
            p.kind = KIND_SPAN;
            p.x_low = OUT_WIDTH'(s_cx - dx);
            p.x_high = OUT_WIDTH'(s_cx + dx);
            p.y_low = OUT_WIDTH'(s_cy + y);
            p.y_high = OUT_WIDTH'(s_cy + y);
            p.done_res = dn;
        end
        else if (ph == RS_RING)
        begin
            x = r_x;
            y = r_y;
            e2 = 2 * r_err;
            if (e2 < (2 * r_x + 1) * r_ry2)
            begin
                r_x++;
                r_err += (2 * r_x + 1) * r_ry2;
                moved = 1;
            end
            if (e2 > -(2 * r_y - 1) * r_rx2)
            begin
                r_y--;
                r_err -= (2 * r_y - 1) * r_rx2;
                moved = 1;
            end
            if (!moved)
                r_y--;
            if (r_y < 0)
            begin
                s_rings--;
                if (s_rings > 0 && s_rx >= 1 && s_ry >= 1)
                begin
                    s_rx--;
                    s_ry--;
                    ring_setup();
                end
                else
                begin
                    ph = RS_IDLE;
                    dn = 1;
                end
            end
            got = 1;
            p.kind = KIND_QUAD;
            p.x_low = OUT_WIDTH'(s_cx - x);
            p.x_high = OUT_WIDTH'(s_cx + x);
            p.y_low = OUT_WIDTH'(s_cy - y);
            p.y_high = OUT_WIDTH'(s_cy + y);
            p.done_res = dn;
        end
    endtask

    // drive one word, wait for acceptance, then predict
    task automatic send_word(input logic f, input logic signed [COORD_WIDTH-1:0] cx,
                             input logic signed [COORD_WIDTH-1:0] cy,
                             input logic [RADIUS_WIDTH-1:0] rx,
                             input logic [RADIUS_WIDTH-1:0] ry,
                             input logic [RADIUS_WIDTH-1:0] bw,
                             input bit typed, input prim_t texp);
        bit got;
        prim_t p;
        req.valid <= 1'b1;
        req.func <= f;
        req.center_x <= cx;
        req.center_y <= cy;
        req.radius_x <= rx;
        req.radius_y <= ry;
        req.border_width <= bw;
        do
            @(posedge clk);
        while (!req.ready);
        raster_step(f, cx, cy, rx, ry, bw, got, p);
        if (typed)
            prim_q = {prim_q, texp};
        else if (got)
            prim_q = {prim_q, p};
        n_items++;
        if (n_items >= QUIET_FROM)
            quiet = 1;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_tick();
        send_word(FUNC_TICK, COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
                  RADIUS_WIDTH'($urandom), RADIUS_WIDTH'($urandom),
                  RADIUS_WIDTH'($urandom), 0, '0);
    endtask

    function automatic void add_row(logic f, int cx, int cy, int rx, int ry, int bw,
                                    int reps, bit typed, prim_t e);
        row_t r;
        r.func = f;
        r.cx = COORD_WIDTH'(cx);
        r.cy = COORD_WIDTH'(cy);
        r.rx = RADIUS_WIDTH'(rx);
        r.ry = RADIUS_WIDTH'(ry);
        r.bw = RADIUS_WIDTH'(bw);
        r.reps = reps;
        r.typed = typed;
        r.exp = e;
        dir_tab = {dir_tab, r};
    endfunction

    function automatic prim_t mk(logic k, int xl, int xh, int yl, int yh, logic d);
        prim_t p;
        p.kind = k;
        p.x_low = OUT_WIDTH'(xl);
        p.x_high = OUT_WIDTH'(xh);
        p.y_low = OUT_WIDTH'(yl);
        p.y_high = OUT_WIDTH'(yh);
        p.done_res = d;
        return p;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (quiet)
            rsp.ready <= 1'b1;
        else if (rsp_stall > 0)
        begin
            rsp_stall <= rsp_stall - 1;
            rsp.ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            rsp_stall <= $urandom_range(0, 7);
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        prim_t e, a;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                a.kind = rsp.kind;
                a.x_low = rsp.x_low;
                a.x_high = rsp.x_high;
                a.y_low = rsp.y_low;
                a.y_high = rsp.y_high;
                a.done_res = rsp.done_res;
                if (prim_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: kind %0d x %0d..%0d y %0d..%0d done %0d",
                                 a.kind, a.x_low, a.x_high, a.y_low, a.y_high, a.done_res);
                end
                else
                begin
                    e = prim_q.pop_front();
                    if (a !== e)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp kind %0d x %0d..%0d y %0d..%0d done %0d",
                                      " / got kind %0d x %0d..%0d y %0d..%0d done %0d"},
                                     e.kind, e.x_low, e.x_high, e.y_low, e.y_high,
                                     e.done_res, a.kind, a.x_low, a.x_high, a.y_low,
                                     a.y_high, a.done_res);
                    end
                end
            end
            if ((rsp.valid && rsp.ready) || (req.valid && req.ready))
                idle_cyc <= 0;
            else if (idle_cyc + 1 >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cyc <= idle_cyc + 1;
        end
    end

    initial
    begin
        int mode, ticks, rx, ry, bw, cut;
        bit drained;
        drained = 0;
        req.valid = 1'b0;
        req.func = FUNC_TICK;
        req.center_x = '0;
        req.center_y = '0;
        req.radius_x = '0;
        req.radius_y = '0;
        req.border_width = '0;

        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 1, 0, '0);
        add_row(FUNC_START, 0, 0, 0, 0, 0, 1, 0, '0);
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 1, 1, mk(KIND_SPAN, 0, 0, 0, 0, 1));
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 1, 0, '0);
        add_row(FUNC_START, 2047, -2048, 1023, 0, 0, 1, 0, '0);
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 1, 1, mk(KIND_SPAN, 1024, 3070, -2048, -2048, 1));
        add_row(FUNC_START, -2048, 2047, 0, 0, 1, 1, 0, '0);
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 1, 1, mk(KIND_SPAN, -2048, -2048, 2047, 2047, 0));
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 1, 1, mk(KIND_QUAD, -2048, -2048, 2047, 2047, 1));
        add_row(FUNC_START, 5, -3, 3, 2, 5, 1, 0, '0);
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 40, 0, '0);
        add_row(FUNC_START, 0, 0, 1, 1, 1023, 1, 0, '0);
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 12, 0, '0);
        add_row(FUNC_START, 2000, 2000, 200, 150, 2, 1, 0, '0);
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 4, 0, '0);
        add_row(FUNC_START, -7, 9, 4, 6, 3, 1, 0, '0);
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 60, 0, '0);
        add_row(FUNC_START, -1, 1, 1023, 1023, 0, 1, 0, '0);
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 40, 0, '0);
        add_row(FUNC_START, 100, -100, 682, 341, 1, 1, 0, '0);
        add_row(FUNC_TICK, 0, 0, 0, 0, 0, 60, 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            for (int k = 0; k < dir_tab[i].reps; k++)
                send_word(dir_tab[i].func, dir_tab[i].cx, dir_tab[i].cy, dir_tab[i].rx,
                          dir_tab[i].ry, dir_tab[i].bw, dir_tab[i].typed, dir_tab[i].exp);

        while (n_items < N_ITEMS)
        begin
            mode = $urandom_range(0, 149);
            if (mode == 0)
            begin
                rx = $urandom_range(0, 1023);
                ry = $urandom_range(0, 1023);
                bw = $urandom_range(0, 1);
            end
            else if (mode < 5)
            begin
                rx = $urandom_range(0, 1023);
                ry = $urandom_range(0, 3);
                bw = $urandom_range(0, 2);
            end
            else
            begin
                rx = $urandom_range(0, 12);
                ry = $urandom_range(0, 12);
                bw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 4);
            end
            send_word(FUNC_START, COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
                      RADIUS_WIDTH'(rx), RADIUS_WIDTH'(ry), RADIUS_WIDTH'(bw), 0, '0);
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : -1;
            ticks = 0;
            while (ph != RS_IDLE && ticks != cut && n_items < N_ITEMS)
            begin
                send_tick();
                ticks++;
            end
            if ($urandom_range(0, 9) == 0)
                send_tick();
            if (!drained && n_items > N_ITEMS / 2)
            begin
                drained = 1;
                req.valid <= 1'b0;
                while (prim_q.size() != 0)
                    @(posedge clk);
            end
        end

        req.valid <= 1'b0;
        while (prim_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
